// ===== src/srng_pkg.sv =====
// shared types and constants for the subtract-with-borrow generator
package srng_pkg;

  localparam int WORD_W       = 25;
  localparam int SEED_W       = 18;
  localparam int DISCARD_W    = 9;
  localparam int GROUP_SIZE   = 24;
  localparam int GROUP_W      = 5;
  localparam int SHORT_LAG    = 10;
  localparam int WARMUP_STEPS = 10;
  localparam int SEED_SCALE_SHIFT = 6;

  localparam logic [WORD_W-1:0]    WORD_BASE     = WORD_W'(25'h100_0000);
  localparam logic [DISCARD_W-1:0] DISCARD_RESET = DISCARD_W'(24);

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  // auxiliary lcg, modulus 259200 = 2^7 * 2025
  localparam int PROD_W        = 31;
  localparam int QUOT_W        = 14;
  localparam int REM_W         = 19;
  localparam int RECIP_W       = 24;
  localparam int RECIP_SHIFT   = 34;
  localparam int MOD_POW2      = 7;
  localparam int RECIP_PROD_W  = 48;

  localparam logic [SEED_W-1:0]  LCG_MOD    = SEED_W'(259200);
  localparam logic [SEED_W-1:0]  LCG_MOD_M1 = SEED_W'(259199);
  localparam logic [PROD_W-1:0]  LCG_MUL    = PROD_W'(7141);
  localparam logic [PROD_W-1:0]  LCG_ADD    = PROD_W'(54773);
  localparam logic [RECIP_W-1:0] LCG_RECIP  = RECIP_W'(8483886);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISCARD,
    ST_DRAW,
    ST_SEED
  } state_t;

  typedef struct packed {
    logic              start;
    logic [SEED_W-1:0] seed;
  } lcg_req_t;

  typedef struct packed {
    logic              done;
    logic [SEED_W-1:0] value;
  } lcg_rsp_t;

endpackage

// ===== src/srng_in_if.sv =====
// request channel: command and seed beat
interface srng_in_if import srng_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [SEED_W-1:0] seed_value;

  modport source (output valid, command, seed_value, input ready);
  modport sink   (input valid, command, seed_value, output ready);
endinterface

// ===== src/srng_out_if.sv =====
// response channel: sample beat
interface srng_out_if import srng_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

// ===== src/srng_ram.sv =====
// generic ram, one write port, two registered read ports
module srng_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/srng_lcg.sv =====
// four-stage step unit of the seeding lcg, j = (j*7141 + 54773) mod 259200
module srng_lcg import srng_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  lcg_req_t req,
  output lcg_rsp_t rsp
);

  logic                      v1, v2, v3, done;
  logic [PROD_W-1:0]         prod;
  logic [QUOT_W-1:0]         quot;
  logic [REM_W-1:0]          rem;
  logic [SEED_W-1:0]         value;
  logic [RECIP_PROD_W-1:0]   recip_prod;
  logic [PROD_W-1:0]         rem_full;

  always_comb begin
    recip_prod = RECIP_PROD_W'(prod[PROD_W-1:MOD_POW2]) * RECIP_PROD_W'(LCG_RECIP);
    rem_full   = prod - PROD_W'(quot) * PROD_W'(LCG_MOD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= req.start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= PROD_W'(req.seed) * LCG_MUL + LCG_ADD;
    end
    if (v1) begin
      // quotient estimate, at most one low
      quot <= recip_prod[RECIP_SHIFT +: QUOT_W];
    end
    if (v2) begin
      rem <= rem_full[REM_W-1:0];
    end
    if (v3) begin
      value <= (rem >= REM_W'(LCG_MOD)) ? SEED_W'(rem - REM_W'(LCG_MOD)) : SEED_W'(rem);
    end
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

// ===== src/subtract_with_borrow_rng.sv =====
// top level of the lagged subtract-with-borrow generator, base 2^24, lags 24 and 10
//
// request channel: a beat with command draw asks for one sample, a beat with command
//   seed refills the lag ring from seed_value and gives no response beat
// response channel: one sample beat per draw, 2^24 minus the new word (1 to 2^24)
// cfg_we / cfg_wdata: sets discard_count, the words dropped after each group of 24
//
// the lag ring sits in a 24-entry ram with registered reads; one generator step per cycle
// unless a final step waits for the output register, the read of step n overlapping the
// write-back of step n-1; a draw inside a group moves the state to draw, where the final
//   step issues once the output register is empty, then returns to idle for the next request;
//   back-to-back draws, even with the response taken at once, each wait for that register
// a draw that opens a new group first runs discard_count steps in the discard state
// seed: 34 steps of the lcg unit, one after another, before the next request is taken
// reset: ring reads as zeros (per-entry valid bits), position and group count cleared,
//   discard_count back to 24
// a stalled response holds the sample; a further draw is taken but its final step
//   waits until the output register is free
module subtract_with_borrow_rng import srng_pkg::*; #(
  parameter int LONG_LAG = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  srng_in_if.sink              request,
  srng_out_if.source           response,
  input  logic                 cfg_we,
  input  logic [DISCARD_W-1:0] cfg_wdata
);

  localparam int AW         = $clog2(LONG_LAG);
  localparam int LAG_OFFSET = LONG_LAG - SHORT_LAG;
  localparam int SEED_STEPS = WARMUP_STEPS + LONG_LAG;
  localparam int SCW        = $clog2(SEED_STEPS);
  localparam logic [SCW-1:0] SEED_LAST = SCW'(SEED_STEPS - 1);

  state_t state, state_next;

  logic [AW-1:0]        pos;
  logic [AW-1:0]        far;
  logic [AW:0]          far_sum;
  logic [GROUP_W-1:0]   group;
  logic [DISCARD_W-1:0] discard_count;
  logic [DISCARD_W-1:0] remaining;
  logic                 carry;
  logic [LONG_LAG-1:0]  ring_valid;
  logic [SCW-1:0]       seed_cnt;

  logic          stg_valid, stg_final, stg_pos_ok, stg_far_ok;
  logic [AW-1:0] stg_pos;

  logic              out_valid;
  logic [WORD_W-1:0] out_sample;

  logic              accept, accept_draw, accept_seed;
  logic              issue, issue_final;
  logic              fill_we;
  logic [AW-1:0]     fill_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] rd_pos, rd_far;
  logic [WORD_W-1:0] a_word, b_word;
  logic [WORD_W:0]   diff;
  logic              borrow;
  logic [WORD_W-1:0] word;
  logic [SEED_W-1:0] seed_clamped;

  lcg_req_t lcg_req;
  lcg_rsp_t lcg_rsp;

  srng_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LONG_LAG)
  ) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (pos),
    .raddr_b (far),
    .rdata_a (rd_pos),
    .rdata_b (rd_far)
  );

  srng_lcg u_lcg (
    .clk (clk),
    .rst (rst),
    .req (lcg_req),
    .rsp (lcg_rsp)
  );

  always_comb begin
    far_sum = {1'b0, pos} + (AW+1)'(LAG_OFFSET);
    far     = (far_sum >= (AW+1)'(LONG_LAG)) ? AW'(far_sum - (AW+1)'(LONG_LAG))
                                             : far_sum[AW-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (request.valid) begin
          if (request.command == CMD_SEED) begin
            state_next = ST_SEED;
          end else if (group >= GROUP_W'(GROUP_SIZE) && discard_count != '0) begin
            state_next = ST_DISCARD;
          end else begin
            state_next = ST_DRAW;
          end
        end
      end
      ST_DISCARD: begin
        if (remaining == DISCARD_W'(1)) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (!out_valid) begin
          state_next = ST_IDLE;
        end
      end
      ST_SEED: begin
        if (lcg_rsp.done && seed_cnt == SEED_LAST) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    request.ready = (state == ST_IDLE);
    accept        = request.valid && request.ready;
    accept_draw   = accept && (request.command == CMD_DRAW);
    accept_seed   = accept && (request.command == CMD_SEED);
    issue_final   = (state == ST_DRAW) && !out_valid;
    issue         = (state == ST_DISCARD) || issue_final;
    seed_clamped  = (request.seed_value >= LCG_MOD) ? LCG_MOD_M1 : request.seed_value;
    lcg_req.start = accept_seed || (state == ST_SEED && lcg_rsp.done && seed_cnt != SEED_LAST);
    lcg_req.seed  = accept_seed ? seed_clamped : lcg_rsp.value;
    fill_we       = (state == ST_SEED) && lcg_rsp.done && (seed_cnt >= SCW'(WARMUP_STEPS));
    fill_addr     = AW'(seed_cnt - SCW'(WARMUP_STEPS));
  end

  // generator step, borrow of the previous step pending on the oldest word
  always_comb begin
    b_word = (stg_pos_ok ? rd_pos : '0) + WORD_W'(carry);
    a_word = stg_far_ok ? rd_far : '0;
    diff   = {1'b0, a_word} - {1'b0, b_word};
    borrow = diff[WORD_W];
    word   = borrow ? diff[WORD_W-1:0] + WORD_BASE : diff[WORD_W-1:0];

    ram_we    = stg_valid || fill_we;
    ram_waddr = stg_valid ? stg_pos : fill_addr;
    ram_wdata = stg_valid ? word : WORD_W'({lcg_rsp.value, {SEED_SCALE_SHIFT{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pos           <= '0;
      group         <= '0;
      discard_count <= DISCARD_RESET;
      remaining     <= '0;
      carry         <= 1'b0;
      ring_valid    <= '0;
      seed_cnt      <= '0;
      stg_valid     <= 1'b0;
      stg_final     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      stg_valid <= issue;
      stg_final <= issue_final;
      if (cfg_we) begin
        discard_count <= cfg_wdata;
      end
      if (accept_draw) begin
        group     <= (group >= GROUP_W'(GROUP_SIZE)) ? GROUP_W'(1) : group + GROUP_W'(1);
        remaining <= discard_count;
      end
      if (accept_seed) begin
        seed_cnt <= '0;
      end
      if (state == ST_DISCARD) begin
        remaining <= remaining - DISCARD_W'(1);
      end
      if (issue) begin
        pos <= (pos == AW'(LONG_LAG - 1)) ? '0 : pos + AW'(1);
      end
      if (stg_valid) begin
        carry               <= borrow;
        ring_valid[stg_pos] <= 1'b1;
      end
      if (out_valid && response.ready) begin
        out_valid <= 1'b0;
      end
      if (stg_valid && stg_final) begin
        out_valid <= 1'b1;
      end
      if (state == ST_SEED && lcg_rsp.done) begin
        seed_cnt <= seed_cnt + SCW'(1);
        if (fill_we) begin
          ring_valid[fill_addr] <= 1'b1;
        end
        if (seed_cnt == SEED_LAST) begin
          pos   <= '0;
          group <= '0;
          carry <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_pos    <= pos;
    stg_pos_ok <= ring_valid[pos];
    stg_far_ok <= ring_valid[far];
    if (stg_valid && stg_final) begin
      out_sample <= WORD_BASE - word;
    end
  end

  assign response.valid  = out_valid;
  assign response.sample = out_sample;

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(stg_valid && fill_we))
    else $error("step write-back and seed fill hit the ram port together");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && stg_final) |-> !out_valid)
    else $error("final step lands on a full output register");

  a_group_range: assert property (@(posedge clk) disable iff (rst)
    group <= GROUP_W'(GROUP_SIZE))
    else $error("group count beyond group size");

  a_lcg_in_seed: assert property (@(posedge clk) disable iff (rst)
    lcg_rsp.done |-> state == ST_SEED)
    else $error("lcg result outside seeding");

  a_seed_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEED && lcg_rsp.done && seed_cnt == SEED_LAST) |=> (pos == '0 && !carry))
    else $error("ring position or borrow not cleared after seeding");

endmodule

// ===== bench/subtract_with_borrow_rng_tb.sv =====
// testbench for subtract_with_borrow_rng: predicts every sample and checks it under random handshakes
`timescale 1ns / 100ps

class sample_predictor;
  localparam int RING_DEPTH = 24;

  logic [srng_pkg::WORD_W-1:0]    ring [RING_DEPTH];
  int unsigned                    position;
  int unsigned                    in_group;
  logic [srng_pkg::DISCARD_W-1:0] discard;
  logic [srng_pkg::WORD_W-1:0]    expected_samples [$];
  int                             mismatches;
  int                             draws;
  int                             reseeds;
  int                             checked;

  function new();
    foreach (ring[i]) ring[i] = '0;
    position   = 0;
    in_group   = 0;
    discard    = srng_pkg::DISCARD_RESET;
    mismatches = 0;
    draws      = 0;
    reseeds    = 0;
    checked    = 0;
  endfunction

  function void set_discard(logic [srng_pkg::DISCARD_W-1:0] value);
    discard = value;
  endfunction

  function longint unsigned lcg_step(longint unsigned j);
    return (j * longint'(srng_pkg::LCG_MUL) + longint'(srng_pkg::LCG_ADD))
           % longint'(srng_pkg::LCG_MOD);
  endfunction

  // one lag step: x[n-10] - x[n-24], borrow carried into the next oldest word
  function logic [srng_pkg::WORD_W-1:0] next_word();
    int unsigned                 cur;
    int unsigned                 far_idx;
    int unsigned                 nxt;
    logic [srng_pkg::WORD_W-1:0] word;
    cur     = position % RING_DEPTH;
    far_idx = (cur + (RING_DEPTH - srng_pkg::SHORT_LAG)) % RING_DEPTH;
    nxt     = (cur + 1) % RING_DEPTH;
    word    = ring[far_idx] - ring[cur];
    if (ring[far_idx] < ring[cur]) begin
      ring[nxt] = ring[nxt] + 1'b1;
      word      = word + srng_pkg::WORD_BASE;
    end
    ring[cur] = word;
    position  = nxt;
    return word;
  endfunction

  function void note_request(logic cmd, logic [srng_pkg::SEED_W-1:0] seed);
    longint unsigned             j;
    logic [srng_pkg::WORD_W-1:0] word;
    if (cmd == srng_pkg::CMD_SEED) begin
      reseeds++;
      j = (seed >= srng_pkg::LCG_MOD) ? longint'(srng_pkg::LCG_MOD_M1) : longint'(seed);
      for (int i = 0; i < srng_pkg::WARMUP_STEPS; i++) j = lcg_step(j);
      for (int i = 0; i < RING_DEPTH; i++) begin
        j       = lcg_step(j);
        ring[i] = srng_pkg::WORD_W'(j << srng_pkg::SEED_SCALE_SHIFT);
      end
      position = 0;
      in_group = 0;
    end else begin
      draws++;
      if (in_group >= srng_pkg::GROUP_SIZE) begin
        for (int i = 0; i < int'(discard); i++) void'(next_word());
        in_group = 0;
      end
      word = next_word();
      in_group++;
      expected_samples.push_back(srng_pkg::WORD_BASE - word);
    end
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_sample(logic [srng_pkg::WORD_W-1:0] sample);
    logic [srng_pkg::WORD_W-1:0] want;
    if (expected_samples.size() == 0) begin
      report($sformatf("sample %0d with no draw outstanding", sample));
    end else begin
      want = expected_samples.pop_front();
      checked++;
      if (sample !== want)
        report($sformatf("sample %0d, expected %0d (beat %0d)", sample, want, checked));
    end
  endtask
endclass

module subtract_with_borrow_rng_tb;
  import srng_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS   = 140;
  localparam int NUM_PHASES    = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [DISCARD_W-1:0] cfg_wdata = '0;
  bit                   no_idle   = 1'b0;
  int                   cycles    = 0;
  int                   settings  = 1;

  sample_predictor predictor = new();

  srng_in_if  request_if ();
  srng_out_if response_if ();

  subtract_with_borrow_rng dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_if),
    .response (response_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  initial begin
    request_if.valid      = 1'b0;
    request_if.command    = CMD_DRAW;
    request_if.seed_value = '0;
    response_if.ready     = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles,
               predictor.expected_samples.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // response side: random stall before each beat
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        response_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      response_if.ready = 1'b1;
      do @(posedge clk); while (!response_if.valid);
      predictor.check_sample(response_if.sample);
      @(negedge clk);
    end
  end

  task send_beat(logic cmd, logic [SEED_W-1:0] seed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      request_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    request_if.valid      = 1'b1;
    request_if.command    = cmd;
    request_if.seed_value = seed;
    do @(posedge clk); while (!request_if.ready);
    predictor.note_request(cmd, seed);
    @(negedge clk);
  endtask

  // hold off requests until every sample is back, then let a reseed finish
  task wait_drained();
    request_if.valid = 1'b0;
    while (predictor.expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task write_discard(logic [DISCARD_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    predictor.set_discard(value);
    @(negedge clk);
    cfg_we = 1'b0;
    settings++;
  endtask

  function logic [SEED_W-1:0] pick_seed();
    if ($urandom_range(0, 3) == 0)
      return SEED_W'($urandom_range(259190, 262143));
    return SEED_W'($urandom);
  endfunction

  initial begin
    logic [DISCARD_W-1:0] discard_plan [NUM_PHASES];
    discard_plan = '{DISCARD_RESET, 9'd0, 9'd365, 9'd511, 9'd1, 9'd0};
    discard_plan[5] = DISCARD_W'($urandom_range(2, 364));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // unseeded ring, then seed extremes and clamp boundary
    repeat (3) send_beat(CMD_DRAW, '0);
    send_beat(CMD_SEED, '0);
    repeat (2) send_beat(CMD_DRAW, '0);
    send_beat(CMD_SEED, '1);
    send_beat(CMD_DRAW, '1);
    send_beat(CMD_SEED, SEED_W'(259200));
    send_beat(CMD_DRAW, '0);
    send_beat(CMD_SEED, SEED_W'(259199));
    send_beat(CMD_DRAW, '0);
    send_beat(CMD_SEED, SEED_W'(1));
    repeat (2) send_beat(CMD_DRAW, '0);
    send_beat(CMD_SEED, SEED_W'(18'h1FFFF));
    send_beat(CMD_DRAW, '0);
    send_beat(CMD_SEED, SEED_W'(18'h2AAAA));
    send_beat(CMD_DRAW, SEED_W'(18'h15555));

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_discard(discard_plan[p]);
      end
      no_idle = (p == 2);
      if ($urandom_range(0, 1) == 0) send_beat(CMD_SEED, pick_seed());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(0, 99) < 6)
          send_beat(CMD_SEED, pick_seed());
        else
          send_beat(CMD_DRAW, SEED_W'($urandom));
      end
    end

    no_idle = 1'b0;
    request_if.valid = 1'b0;
    while (predictor.expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (predictor.expected_samples.size() != 0)
      predictor.report($sformatf("%0d samples never arrived",
                                 predictor.expected_samples.size()));
    $display("%0d draws and %0d reseeds sent, %0d samples checked",
             predictor.draws, predictor.reseeds, predictor.checked);
    $display("%0d discard settings including 0, 365 and 511, with and without idling",
             settings);
    if (predictor.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== subtract_with_borrow_rng.f =====
src/srng_pkg.sv
src/srng_in_if.sv
src/srng_out_if.sv
src/srng_ram.sv
src/srng_lcg.sv
src/subtract_with_borrow_rng.sv
bench/subtract_with_borrow_rng_tb.sv
